// ===== src/gbt_pkg.sv =====
package gbt_pkg;

    // Store geometry.
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int BYTE_W   = 8;

    // Field widths of the stream items.
    localparam int COL_W    = 16;
    localparam int LINE_W   = 12;
    localparam int OFS_W    = 13;
    localparam int TAB_W    = 5;

    // Special bytes and reset values.
    localparam logic [BYTE_W-1:0] NL_BYTE   = 8'd10;
    localparam logic [BYTE_W-1:0] TAB_BYTE  = 8'd9;
    localparam logic [TAB_W-1:0]  TAB_RESET = 5'd8;

    // Register addresses.
    localparam logic [2:0] REG_TAB_COLUMNS = 3'd0;

    typedef enum logic [3:0] {
        OP_INSERT = 4'd0,
        OP_DELETE = 4'd1,
        OP_LEFT   = 4'd2,
        OP_RIGHT  = 4'd3,
        OP_BOL    = 4'd4,
        OP_EOL    = 4'd5,
        OP_NEXT   = 4'd6,
        OP_PREV   = 4'd7,
        OP_QUERY  = 4'd8
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Saturating column advance by the display width of one byte.
    function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [TAB_W-1:0] tab);
        logic [COL_W:0] sum;
        sum = {1'b0, c} + ((b == TAB_BYTE) ? (COL_W+1)'(tab) : (COL_W+1)'(1));
        return sum[COL_W] ? {COL_W{1'b1}} : sum[COL_W-1:0];
    endfunction

endpackage

// ===== src/gbt_ram.sv =====
module gbt_ram
    import gbt_pkg::*;
#(
    parameter int AW = ADDR_W,
    parameter int DW = BYTE_W
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gap_buffer_text_engine.sv =====
// Gap-buffer text engine: one transaction in, one result transaction out.
// The time from acceptance to result valid grows with the bytes between line start and
// cursor, which the column count walks (a newline that ends the count adds a read), with
// each byte moved or scanned and the check that ends each walk; text reads go one at a time.
// One command at a time: the next is accepted in the cycle after the result loads.
// Reset (rst_n low, asynchronous) empties the text and sets tab width to 8.
module gap_buffer_text_engine
    import gbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream: [3:0] opcode, [11:4] data_byte, [15:12] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Master stream: [7:0] current_byte, [20:8] cursor_offset, [32:21] line_number,
    // [48:33] column_number, [61:49] text_length, [63:62] status.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_US,
        S_MOVE_RD,
        S_MOVE_US,
        S_COL_RD,
        S_COL_US,
        S_CUR,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_LEFT1,
        M_RIGHT1,
        M_BOL,
        M_EOL,
        M_COL
    } mode_t;

    localparam logic [PTR_W-1:0] CAP_PTR = PTR_W'(CAPACITY);

    // Sequence of cursor moves that one command performs.
    function automatic mode_t plan_mode(input opcode_t op, input logic [2:0] idx);
        mode_t m;
        m = M_NONE;
        case (op)
            OP_LEFT:  m = (idx == 3'd0) ? M_LEFT1 : M_NONE;
            OP_RIGHT: m = (idx == 3'd0) ? M_RIGHT1 : M_NONE;
            OP_BOL:   m = (idx == 3'd0) ? M_BOL : M_NONE;
            OP_EOL:   m = (idx == 3'd0) ? M_EOL : M_NONE;
            OP_NEXT:
            begin
                case (idx)
                    3'd0:    m = M_EOL;
                    3'd1:    m = M_RIGHT1;
                    3'd2:    m = M_COL;
                    default: m = M_NONE;
                endcase
            end
            OP_PREV:
            begin
                case (idx)
                    3'd0:    m = M_BOL;
                    3'd1:    m = M_LEFT1;
                    3'd2:    m = M_BOL;
                    3'd3:    m = M_COL;
                    default: m = M_NONE;
                endcase
            end
            default: m = M_NONE;
        endcase
        return m;
    endfunction

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    opcode_t                op_reg, op_next;
    logic [2:0]             plan_reg, plan_next;
    logic [PTR_W-1:0]       gs_reg, gs_next;
    logic [PTR_W-1:0]       ge_reg, ge_next;
    logic [PTR_W-1:0]       line_reg, line_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [COL_W-1:0]       cnt_reg, cnt_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    status_t                status_reg, status_next;
    logic [TAB_W-1:0]       tab_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [63:0]            m_tdata_reg, m_tdata_next;

    logic                   wr_en;
    logic [ADDR_W-1:0]      waddr;
    logic [BYTE_W-1:0]      wdata;
    logic [ADDR_W-1:0]      raddr;
    logic [BYTE_W-1:0]      rdata;

    logic                   at_end;
    logic                   s_accept;
    logic                   done;
    logic                   start_col;
    logic                   cfg_write;
    opcode_t                op_in;
    logic [PTR_W-1:0]       ge_dec;
    logic [PTR_W-1:0]       gs_dec;
    logic [PTR_W-1:0]       ptr_dec;
    logic [OFS_W-1:0]       text_len;
    logic [LINE_W-1:0]      line_out;
    logic [BYTE_W-1:0]      cur_byte;

    gbt_ram u_ram
    (
        .clk   (clk),
        .wr_en (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign at_end   = (ge_reg == CAP_PTR);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign op_in    = opcode_t'(s_tdata[3:0]);
    assign ge_dec   = ge_reg - PTR_W'(1);
    assign gs_dec   = gs_reg - PTR_W'(1);
    assign ptr_dec  = ptr_reg - PTR_W'(1);

    // Result fields.
    assign text_len = OFS_W'(CAP_PTR - (ge_reg - gs_reg));
    assign line_out = (line_reg > PTR_W'({LINE_W{1'b1}})) ? {LINE_W{1'b1}}
                                                          : line_reg[LINE_W-1:0];
    assign cur_byte = at_end ? '0 : rdata;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == REG_TAB_COLUMNS) ? {{(32-TAB_W){1'b0}}, tab_reg} : '0;

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        op_next       = op_reg;
        plan_next     = plan_reg;
        gs_next       = gs_reg;
        ge_next       = ge_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        waddr         = gs_reg[ADDR_W-1:0];
        wdata         = rdata;
        raddr         = ge_reg[ADDR_W-1:0];
        done          = 1'b0;
        start_col     = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next     = op_in;
                    plan_next   = 3'd0;
                    status_next = ST_OK;
                    cnt_next    = '0;
                    case (op_in)
                        OP_INSERT:
                        begin
                            if (gs_reg == ge_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                waddr   = gs_reg[ADDR_W-1:0];
                                wdata   = s_tdata[11:4];
                                gs_next = gs_reg + PTR_W'(1);
                                if (s_tdata[11:4] == NL_BYTE)
                                begin
                                    line_next = line_reg + PTR_W'(1);
                                end
                            end
                            start_col = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            if (at_end)
                            begin
                                status_next = ST_BOUND;
                            end
                            else
                            begin
                                ge_next = ge_reg + PTR_W'(1);
                            end
                            start_col = 1'b1;
                        end
                        OP_LEFT:
                        begin
                            if (gs_reg == '0)
                            begin
                                status_next = ST_BOUND;
                                start_col   = 1'b1;
                            end
                            else
                            begin
                                mode_next  = M_LEFT1;
                                state_next = S_MOVE_RD;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (at_end)
                            begin
                                status_next = ST_BOUND;
                                start_col   = 1'b1;
                            end
                            else
                            begin
                                mode_next  = M_RIGHT1;
                                state_next = S_MOVE_RD;
                            end
                        end
                        OP_BOL, OP_EOL:
                        begin
                            mode_next  = plan_mode(op_in, 3'd0);
                            state_next = S_MOVE_RD;
                        end
                        OP_NEXT:
                        begin
                            ptr_next   = ge_reg;
                            state_next = S_SCAN_RD;
                        end
                        OP_PREV:
                        begin
                            ptr_next   = gs_reg;
                            state_next = S_SCAN_RD;
                        end
                        default:
                        begin
                            start_col = 1'b1;
                        end
                    endcase
                end
            end

            // Look for a newline without moving the cursor.
            S_SCAN_RD:
            begin
                if (op_reg == OP_NEXT)
                begin
                    if (ptr_reg == CAP_PTR)
                    begin
                        status_next = ST_BOUND;
                        start_col   = 1'b1;
                    end
                    else
                    begin
                        raddr      = ptr_reg[ADDR_W-1:0];
                        state_next = S_SCAN_US;
                    end
                end
                else
                begin
                    if (ptr_reg == '0)
                    begin
                        status_next = ST_BOUND;
                        start_col   = 1'b1;
                    end
                    else
                    begin
                        raddr      = ptr_dec[ADDR_W-1:0];
                        state_next = S_SCAN_US;
                    end
                end
            end

            S_SCAN_US:
            begin
                if (rdata == NL_BYTE)
                begin
                    plan_next  = 3'd0;
                    mode_next  = plan_mode(op_reg, 3'd0);
                    cnt_next   = '0;
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    ptr_next   = (op_reg == OP_NEXT) ? ptr_reg + PTR_W'(1) : ptr_dec;
                    state_next = S_SCAN_RD;
                end
            end

            // Check the end condition of the move and fetch the byte to carry.
            S_MOVE_RD:
            begin
                if (mode_reg == M_LEFT1 || mode_reg == M_BOL)
                begin
                    if (gs_reg == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        raddr      = gs_dec[ADDR_W-1:0];
                        state_next = S_MOVE_US;
                    end
                end
                else if (mode_reg == M_NONE || at_end ||
                         (mode_reg == M_COL && cnt_reg >= col_reg))
                begin
                    done = 1'b1;
                end
                else
                begin
                    raddr      = ge_reg[ADDR_W-1:0];
                    state_next = S_MOVE_US;
                end
            end

            // Carry one byte across the gap, unless a newline ends the move.
            S_MOVE_US:
            begin
                state_next = S_MOVE_RD;
                if (mode_reg == M_LEFT1 || mode_reg == M_BOL)
                begin
                    if (mode_reg == M_BOL && rdata == NL_BYTE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        waddr   = ge_dec[ADDR_W-1:0];
                        gs_next = gs_dec;
                        ge_next = ge_dec;
                        if (rdata == NL_BYTE && line_reg != '0)
                        begin
                            line_next = line_reg - PTR_W'(1);
                        end
                        done = (mode_reg == M_LEFT1);
                    end
                end
                else
                begin
                    if (mode_reg != M_RIGHT1 && rdata == NL_BYTE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        waddr   = gs_reg[ADDR_W-1:0];
                        gs_next = gs_reg + PTR_W'(1);
                        ge_next = ge_reg + PTR_W'(1);
                        if (rdata == NL_BYTE)
                        begin
                            line_next = line_reg + PTR_W'(1);
                        end
                        if (mode_reg == M_COL)
                        begin
                            cnt_next = col_add(cnt_reg, rdata, tab_reg);
                        end
                        done = (mode_reg == M_RIGHT1);
                    end
                end
            end

            // Walk back to the line start to count the display column.
            S_COL_RD:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = S_CUR;
                end
                else
                begin
                    raddr      = ptr_dec[ADDR_W-1:0];
                    state_next = S_COL_US;
                end
            end

            S_COL_US:
            begin
                if (rdata == NL_BYTE)
                begin
                    state_next = S_CUR;
                end
                else
                begin
                    ptr_next   = ptr_dec;
                    cnt_next   = col_add(cnt_reg, rdata, tab_reg);
                    state_next = S_COL_RD;
                end
            end

            // Fetch the byte after the cursor.
            S_CUR:
            begin
                col_next   = cnt_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {status_reg, text_len, col_reg, line_out,
                                     gs_reg[OFS_W-1:0], cur_byte};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance to the next move of the command, or on to the column count.
        if (done)
        begin
            plan_next = plan_reg + 3'd1;
            mode_next = plan_mode(op_reg, plan_reg + 3'd1);
            cnt_next  = '0;
            if (plan_mode(op_reg, plan_reg + 3'd1) == M_NONE)
            begin
                start_col = 1'b1;
            end
            else
            begin
                state_next = S_MOVE_RD;
            end
        end

        if (start_col)
        begin
            ptr_next   = gs_next;
            cnt_next   = '0;
            state_next = S_COL_RD;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_NONE;
            op_reg       <= OP_QUERY;
            plan_reg     <= '0;
            gs_reg       <= '0;
            ge_reg       <= CAP_PTR;
            line_reg     <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            status_reg   <= ST_OK;
            tab_reg      <= TAB_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            op_reg       <= op_next;
            plan_reg     <= plan_next;
            gs_reg       <= gs_next;
            ge_reg       <= ge_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            if (cfg_write && paddr == REG_TAB_COLUMNS)
            begin
                tab_reg <= pwdata[TAB_W-1:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The gap never has negative size.
    assert property (@(posedge clk) disable iff (!rst_n) gs_reg <= ge_reg)
        else $error("gap start beyond gap end");

    // An accepted command always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n) s_accept |=> state_reg != S_IDLE)
        else $error("command accepted without work");

    // Text writes land only at the gap edges.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (waddr == gs_reg[ADDR_W-1:0] || waddr == ge_dec[ADDR_W-1:0]))
        else $error("text write away from gap");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import gbt_pkg::*;

    // Opcodes with no function; the block treats them as a query.
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PER_PHASE = 180;

    // One result transaction, laid out exactly as on m_tdata.
    typedef struct packed {
        logic [1:0]       st;
        logic [OFS_W-1:0] len;
        logic [COL_W-1:0] col;
        logic [LINE_W-1:0] line;
        logic [OFS_W-1:0] ofs;
        logic [BYTE_W-1:0] cur;
    } cursor_rpt_t;

    typedef struct {
        logic [3:0]  op;
        logic [7:0]  data;
        bit          typed;
        cursor_rpt_t rpt;
    } edit_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gap_buffer_text_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the text engine state.
    logic [7:0]       txt [CAPACITY];
    int               gs;
    int               ge;
    int               cur_line;
    int               cur_col;
    logic [TAB_W-1:0] tab_w;

    cursor_rpt_t cursor_q [$];
    edit_cmd_t   dir_rows [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_left;
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int byte_cols(logic [7:0] b);
        return (b == TAB_BYTE) ? int'(tab_w) : 1;
    endfunction

    function automatic int col_sat(int a, int b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    function automatic int text_len();
        return CAPACITY - (ge - gs);
    endfunction

    // Gap moves by one byte; callers check the boundary.
    function automatic void shift_right();
        logic [7:0] b;
        b = txt[ge];
        if (b == NL_BYTE)
            cur_line++;
        txt[gs] = b;
        gs++;
        ge++;
    endfunction

    function automatic void shift_left();
        gs--;
        ge--;
        txt[ge] = txt[gs];
        if (txt[ge] == NL_BYTE && cur_line > 0)
            cur_line--;
    endfunction

    function automatic void seek_bol();
        while (gs > 0 && txt[gs-1] != NL_BYTE)
            shift_left();
    endfunction

    function automatic void seek_eol();
        while (ge < CAPACITY && txt[ge] != NL_BYTE)
            shift_right();
    endfunction

    function automatic void seek_col(int goal);
        int c;
        c = 0;
        while (c < goal && ge < CAPACITY && txt[ge] != NL_BYTE)
        begin
            c = col_sat(c, byte_cols(txt[ge]));
            shift_right();
        end
    endfunction

    // Apply one command to the shadow state and return the cursor report.
    function automatic cursor_rpt_t apply_edit(logic [3:0] op, logic [7:0] data);
        cursor_rpt_t r;
        logic [1:0] st;
        int goal;
        int p;
        int c;
        st = ST_OK;
        goal = cur_col;
        case (op)
            OP_INSERT:
                if (gs >= ge)
                    st = ST_FULL;
                else
                begin
                    txt[gs] = data;
                    gs++;
                    if (data == NL_BYTE)
                        cur_line++;
                end
            OP_DELETE:
                if (ge >= CAPACITY)
                    st = ST_BOUND;
                else
                    ge++;
            OP_LEFT:
                if (gs == 0)
                    st = ST_BOUND;
                else
                    shift_left();
            OP_RIGHT:
                if (ge >= CAPACITY)
                    st = ST_BOUND;
                else
                    shift_right();
            OP_BOL:
                seek_bol();
            OP_EOL:
                seek_eol();
            OP_NEXT:
            begin
                p = ge;
                while (p < CAPACITY && txt[p] != NL_BYTE)
                    p++;
                if (p >= CAPACITY)
                    st = ST_BOUND;
                else
                begin
                    seek_eol();
                    shift_right();
                    seek_col(goal);
                end
            end
            OP_PREV:
            begin
                p = gs;
                while (p > 0 && txt[p-1] != NL_BYTE)
                    p--;
                if (p == 0)
                    st = ST_BOUND;
                else
                begin
                    seek_bol();
                    shift_left();
                    seek_bol();
                    seek_col(goal);
                end
            end
            default:
                ;
        endcase
        // Column is recounted from the line start after every command.
        c = 0;
        p = gs;
        while (p > 0 && txt[p-1] != NL_BYTE)
        begin
            p--;
            c = col_sat(c, byte_cols(txt[p]));
        end
        cur_col = c;
        r.cur  = (ge >= CAPACITY) ? 8'd0 : txt[ge];
        r.ofs  = OFS_W'(gs);
        r.line = (cur_line > 4095) ? 12'd4095 : LINE_W'(cur_line);
        r.col  = COL_W'(cur_col);
        r.len  = OFS_W'(text_len());
        r.st   = st;
        return r;
    endfunction

    function automatic void add_row(logic [3:0] op, logic [7:0] data);
        edit_cmd_t e;
        e.op = op;
        e.data = data;
        e.typed = 1'b0;
        e.rpt = '0;
        dir_rows.push_back(e);
    endfunction

    function automatic void add_row_exp(logic [3:0] op, logic [7:0] data, logic [7:0] cur,
                                        int ofs, int line, int col, int len,
                                        logic [1:0] st);
        edit_cmd_t e;
        e.op = op;
        e.data = data;
        e.typed = 1'b1;
        e.rpt = {st, OFS_W'(len), COL_W'(col), LINE_W'(line), OFS_W'(ofs), cur};
        dir_rows.push_back(e);
    endfunction

    // Random command, biased toward short lines and a text of a few hundred bytes.
    function automatic edit_cmd_t random_edit();
        edit_cmd_t e;
        int pick;
        e.typed = 1'b0;
        e.rpt = '0;
        e.data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 36)
        begin
            e.op = OP_INSERT;
            if ($urandom_range(99) < 15)
                e.data = NL_BYTE;
            else if ($urandom_range(99) < 12)
                e.data = TAB_BYTE;
            if (text_len() > 500)
                e.op = OP_DELETE;
        end
        else if (pick < 48)
            e.op = OP_DELETE;
        else if (pick < 58)
            e.op = OP_LEFT;
        else if (pick < 68)
            e.op = OP_RIGHT;
        else if (pick < 74)
            e.op = OP_BOL;
        else if (pick < 80)
            e.op = OP_EOL;
        else if (pick < 88)
            e.op = OP_NEXT;
        else if (pick < 96)
            e.op = OP_PREV;
        else if (pick < 98)
            e.op = OP_QUERY;
        else
            e.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        return e;
    endfunction

    // Offer one command on the input stream and record its expected report.
    task automatic send_edit(edit_cmd_t e);
        cursor_rpt_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, e.data, e.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = apply_edit(e.op, e.data);
        cursor_q.push_back(e.typed ? e.rpt : r);
    endtask

    // Stop offering and wait until every expected report has come.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (cursor_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, then a read back of the same register.
    task automatic write_tab(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TAB_COLUMNS;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tab_w = value[TAB_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[TAB_W-1:0] !== tab_w)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tab_columns read back: expected %0d, got %0d", tab_w,
                         prdata[TAB_W-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Empty the text: step left at the end of the text, else delete.
    task automatic clear_text();
        edit_cmd_t e;
        e.typed = 1'b0;
        e.rpt = '0;
        e.data = 8'h00;
        while (text_len() > 0)
        begin
            e.op = (ge >= CAPACITY) ? OP_LEFT : OP_DELETE;
            send_edit(e);
        end
    endtask

    // Result side: compare each report and drive the ready pattern.
    always @(posedge clk)
    begin
        cursor_rpt_t got;
        cursor_rpt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (cursor_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction %h", m_tdata);
            end
            else
            begin
                want = cursor_q.pop_front();
                if (got.cur !== want.cur || got.ofs !== want.ofs || got.line !== want.line ||
                    got.col !== want.col || got.len !== want.len || got.st !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch byte/ofs/line/col/len/status: expected ",
                                  "%0d/%0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d/%0d"},
                                 want.cur, want.ofs, want.line, want.col, want.len,
                                 want.st, got.cur, got.ofs, got.line, got.col, got.len,
                                 got.st);
                end
            end
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        logic [31:0] tab_vals [4];
        send_pct = '{0, 76, 0, 18};
        recv_pct = '{0, 0, 76, 18};
        tab_vals = '{32'd16, 32'd1, 32'd31, 32'd0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        idle_cycles = 0;
        gs = 0;
        ge = CAPACITY;
        cur_line = 0;
        cur_col = 0;
        tab_w = TAB_RESET;

        // Directed commands on the empty text with the reset tab width.
        add_row_exp(OP_QUERY, 8'h00, 8'd0, 0, 0, 0, 0, ST_OK);
        add_row_exp(OP_DELETE, 8'h00, 8'd0, 0, 0, 0, 0, ST_BOUND);
        add_row_exp(OP_LEFT, 8'h00, 8'd0, 0, 0, 0, 0, ST_BOUND);
        add_row_exp(OP_RIGHT, 8'h00, 8'd0, 0, 0, 0, 0, ST_BOUND);
        add_row_exp(OP_NEXT, 8'h00, 8'd0, 0, 0, 0, 0, ST_BOUND);
        add_row_exp(OP_PREV, 8'h00, 8'd0, 0, 0, 0, 0, ST_BOUND);
        add_row_exp(OP_BOL, 8'h00, 8'd0, 0, 0, 0, 0, ST_OK);
        add_row_exp(OP_EOL, 8'h00, 8'd0, 0, 0, 0, 0, ST_OK);
        add_row_exp(OP_INSERT, 8'h41, 8'd0, 1, 0, 1, 1, ST_OK);
        add_row_exp(OP_INSERT, TAB_BYTE, 8'd0, 2, 0, 9, 2, ST_OK);
        add_row_exp(OP_INSERT, NL_BYTE, 8'd0, 3, 1, 0, 3, ST_OK);
        add_row_exp(OP_INSERT, 8'hFF, 8'd0, 4, 1, 1, 4, ST_OK);
        add_row_exp(OP_INSERT, 8'h00, 8'd0, 5, 1, 2, 5, ST_OK);
        // A line move keeps the goal column; the tab carries it past it.
        add_row_exp(OP_PREV, 8'h00, NL_BYTE, 2, 0, 9, 5, ST_OK);
        add_row_exp(OP_NEXT, 8'h00, 8'd0, 5, 1, 2, 5, ST_OK);
        add_row_exp(OP_LEFT, 8'h00, 8'h00, 4, 1, 1, 5, ST_OK);
        add_row_exp(OP_LEFT, 8'h00, 8'hFF, 3, 1, 0, 5, ST_OK);
        add_row(OP_BOL, 8'hAA);
        add_row(OP_EOL, 8'h55);
        add_row(OP_PREV, 8'h00);
        add_row(OP_DELETE, 8'h00);
        add_row(OP_UNUSED_LO, 8'h00);
        add_row(OP_UNUSED_HI, 8'hFF);
        add_row(OP_RIGHT, 8'h00);
        add_row(OP_QUERY, 8'h00);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_edit(dir_rows[i]);

        clear_text();

        // Random phases, each with its own tab width and flow pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_reports();
            write_tab(tab_vals[ph]);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0)
                hold_req = 1'b1;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (ph == 1 && n == RAND_PER_PHASE / 2)
                    drain_reports();
                send_edit(random_edit());
            end
        end
        s_tvalid <= 1'b0;

        while (cursor_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/gbt_pkg.sv
src/gbt_ram.sv
src/gap_buffer_text_engine.sv
tb/testbench.sv
